// ----- hw/rtl/pic_pkg.sv -----
`timescale 1ns / 1ps

package pic_pkg;

  // Number of interrupt sources the bus registers are built for.
  localparam int unsigned MaxSources = 8;
  localparam int unsigned RegW       = 8;
  localparam int unsigned LevelW     = 3;
  localparam int unsigned VectorW    = 11;
  localparam int unsigned CmdW       = 2;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  // Bus register map.
  localparam logic [RegW-1:0] AddrBase   = 8'hB0;
  localparam logic [RegW-1:0] AddrEnable = 8'hB2;
  localparam logic [RegW-1:0] AddrAck    = 8'hB6;

  typedef enum logic [CmdW-1:0] {
    CMD_RAISE = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CHECK = 2'd3
  } cmd_e;

  // Result of the priority search.
  typedef struct packed {
    logic              found;
    logic [LevelW-1:0] level;
  } prio_t;

endpackage

// ----- hw/rtl/pic_prio_enc.sv -----
`timescale 1ns / 1ps

module pic_prio_enc #(
  parameter int unsigned NUM_SOURCES = pic_pkg::MaxSources
) (
  input  logic [NUM_SOURCES-1:0] active_i,
  output pic_pkg::prio_t         prio_o
);
  import pic_pkg::*;

  // The lowest active index wins, so scan from the top down and let lower
  // indices overwrite.
  always_comb begin
    prio_o.found = 1'b0;
    prio_o.level = '0;
    for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
      if (active_i[i]) begin
        prio_o.found = 1'b1;
        prio_o.level = LevelW'(i);
      end
    end
  end

endmodule

// ----- hw/rtl/priority_interrupt_controller_core.sv -----
`timescale 1ns / 1ps

// Eight-source priority interrupt controller with a stream command port.
// Each transfer on the slave side carries one command in s_axis_tuser_i
// (raise a source, bus write, bus read, check for delivery) plus its address,
// write byte and source index in s_axis_tdata_i. Each command yields exactly
// one result transfer on the master side: the read byte, whether an enabled
// source is pending, the winning level, its vector (base + level) * 4 and the
// deliver flag for a check command.
// The register update and the priority search are done in the cycle of the
// transfer and the result lands in the output register.
// Throughput is one command per cycle while results are taken; the single output
// register is refilled in the same cycle it is drained.
// When the receiver stalls, the result waits in the output register and
// s_axis_tready_o drops until it is taken. Reset clears the vector base, the
// enable mask, the pending bits and the output valid.
module priority_interrupt_controller_core #(
  parameter int unsigned NUM_SOURCES = pic_pkg::MaxSources
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // address[7:0], write_data[15:8], source_line[18:16], zero[23:19]
  input  logic [pic_pkg::InDataW-1:0]   s_axis_tdata_i,
  // command[1:0]
  input  logic [pic_pkg::CmdW-1:0]      s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // read_data[7:0], irq_pending[8], irq_level[11:9], irq_vector[22:12],
  // deliver[23]
  output logic [pic_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import pic_pkg::*;

  localparam logic [RegW-1:0] ValidMask = RegW'((9'd1 << NUM_SOURCES) - 9'd1);

  logic [RegW-1:0]    base_q, base_d;
  logic [RegW-1:0]    enable_q, enable_d;
  logic [RegW-1:0]    pending_q, pending_d;
  logic               out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic               accept;
  cmd_e               cmd;
  logic [RegW-1:0]    address;
  logic [RegW-1:0]    write_data;
  logic [LevelW-1:0]  source_line;
  prio_t              prio;
  logic [RegW-1:0]    read_data;
  logic [VectorW-1:0] vector;
  logic               deliver;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign cmd         = cmd_e'(s_axis_tuser_i);
  assign address     = s_axis_tdata_i[7:0];
  assign write_data  = s_axis_tdata_i[15:8];
  assign source_line = s_axis_tdata_i[18:16];

  // Next register state for this command.
  always_comb begin
    base_d    = base_q;
    enable_d  = enable_q;
    pending_d = pending_q;
    case (cmd)
      CMD_RAISE: begin
        pending_d = pending_q | ((RegW'(1) << source_line) & enable_q & ValidMask);
      end
      CMD_WRITE: begin
        unique case (address)
          AddrBase:   base_d = write_data;
          AddrEnable: begin
            enable_d  = write_data;
            pending_d = pending_q & write_data;
          end
          AddrAck:    pending_d = pending_q & ~write_data;
          default:    ;
        endcase
      end
      default: ;
    endcase
  end

  pic_prio_enc #(
    .NUM_SOURCES(NUM_SOURCES)
  ) u_prio_enc (
    .active_i(pending_d[NUM_SOURCES-1:0] & enable_d[NUM_SOURCES-1:0]),
    .prio_o  (prio)
  );

  always_comb begin
    read_data = '0;
    if (cmd == CMD_READ) begin
      unique case (address)
        AddrBase:   read_data = base_d;
        AddrEnable: read_data = enable_d;
        AddrAck:    read_data = RegW'(1) << prio.level;
        default:    read_data = '0;
      endcase
    end
  end

  assign vector  = prio.found
                   ? {({1'b0, base_d} + {6'd0, prio.level}), 2'b00}
                   : '0;
  assign deliver = (cmd == CMD_CHECK) && prio.found;

  assign out_data_d = {deliver, vector, prio.level, prio.found, read_data};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      enable_q    <= '0;
      pending_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        base_q    <= base_d;
        enable_q  <= enable_d;
        pending_q <= pending_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // A source can only be pending while it is enabled and exists.
  a_pending_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q & ~(enable_q & ValidMask)) == '0)
    else $error("pending bit set for a disabled or absent source");

  // An accepted command always leaves a result in the output register.
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid_o)
    else $error("accepted command produced no result");

  // With nothing pending, level and vector read zero and nothing is delivered.
  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[8]) |->
      (m_axis_tdata_o[23:9] == '0))
    else $error("nonzero level, vector or deliver with nothing pending");

  // The result register holds its contents while the receiver stalls.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(out_data_q))
    else $error("result register changed under stall");

endmodule

// ----- tb/sv/priority_interrupt_controller_core_tb.sv -----
`timescale 1ns / 1ps

module priority_interrupt_controller_core_tb;
  import pic_pkg::*;

  localparam int unsigned RandomItems = 550;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned IdlePercent = 31;

  // Field order matches m_axis_tdata_o from the top bit down.
  typedef struct packed {
    logic               deliver;
    logic [VectorW-1:0] vector;
    logic [LevelW-1:0]  level;
    logic               pending;
    logic [RegW-1:0]    read_data;
  } irq_result_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [RegW-1:0]   addr;
    logic [RegW-1:0]   wdata;
    logic [LevelW-1:0] src;
    logic              has_result;
    irq_result_t       result;
  } stim_row_t;

  // Rows with has_result set carry a hand-written expectation; the others
  // are checked against the shadow registers.
  localparam stim_row_t DirectedRows [25] = '{
    '{CMD_READ,  AddrBase,   8'h00, 3'd0, 1'b1, '{1'b0, 11'd0, 3'd0, 1'b0, 8'h00}},
    '{CMD_READ,  AddrEnable, 8'h00, 3'd0, 1'b1, '{1'b0, 11'd0, 3'd0, 1'b0, 8'h00}},
    '{CMD_READ,  AddrAck,    8'h00, 3'd0, 1'b1, '{1'b0, 11'd0, 3'd0, 1'b0, 8'h01}},
    '{CMD_CHECK, 8'h00,      8'h00, 3'd0, 1'b1, '{1'b0, 11'd0, 3'd0, 1'b0, 8'h00}},
    '{CMD_RAISE, 8'h00,      8'h00, 3'd3, 1'b1, '{1'b0, 11'd0, 3'd0, 1'b0, 8'h00}},
    '{CMD_READ,  AddrAck,    8'h00, 3'd0, 1'b1, '{1'b0, 11'd0, 3'd0, 1'b0, 8'h01}},
    '{CMD_WRITE, AddrBase,   8'hFF, 3'd0, 1'b1, '{1'b0, 11'd0, 3'd0, 1'b0, 8'h00}},
    '{CMD_WRITE, AddrEnable, 8'hFF, 3'd0, 1'b1, '{1'b0, 11'd0, 3'd0, 1'b0, 8'h00}},
    '{CMD_RAISE, 8'h00,      8'h00, 3'd7, 1'b1, '{1'b0, 11'd1048, 3'd7, 1'b1, 8'h00}},
    '{CMD_CHECK, 8'h00,      8'h00, 3'd0, 1'b1, '{1'b1, 11'd1048, 3'd7, 1'b1, 8'h00}},
    '{CMD_READ,  AddrAck,    8'h00, 3'd0, 1'b1, '{1'b0, 11'd1048, 3'd7, 1'b1, 8'h80}},
    '{CMD_RAISE, 8'h00,      8'h00, 3'd0, 1'b0, '0},
    '{CMD_WRITE, AddrAck,    8'h01, 3'd0, 1'b0, '0},
    '{CMD_WRITE, AddrEnable, 8'h0F, 3'd0, 1'b0, '0},
    '{CMD_READ,  AddrEnable, 8'h00, 3'd0, 1'b0, '0},
    '{CMD_RAISE, 8'h00,      8'h00, 3'd2, 1'b0, '0},
    '{CMD_RAISE, 8'h00,      8'h00, 3'd6, 1'b0, '0},
    '{CMD_WRITE, 8'h55,      8'hFF, 3'd0, 1'b0, '0},
    '{CMD_READ,  8'h00,      8'h00, 3'd0, 1'b0, '0},
    '{CMD_READ,  8'hFF,      8'h00, 3'd0, 1'b0, '0},
    '{CMD_WRITE, AddrBase,   8'h00, 3'd0, 1'b0, '0},
    '{CMD_CHECK, 8'hFF,      8'hFF, 3'd7, 1'b0, '0},
    '{CMD_WRITE, AddrAck,    8'h00, 3'd0, 1'b0, '0},
    '{CMD_WRITE, AddrAck,    8'hFF, 3'd0, 1'b0, '0},
    '{CMD_CHECK, 8'h00,      8'h00, 3'd0, 1'b0, '0}
  };

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                s_valid = 1'b0;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [CmdW-1:0]     s_tuser = '0;
  logic                m_ready = 1'b0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;

  logic [RegW-1:0] shadow_base = '0;
  logic [RegW-1:0] shadow_mask = '0;
  logic [RegW-1:0] shadow_pend = '0;

  irq_result_t irq_result_q[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          steady         = 1'b0;

  priority_interrupt_controller_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Applies one command to the shadow registers and returns what the block
  // must report for it.
  function automatic irq_result_t compute_irq_result(cmd_e cmd, logic [RegW-1:0] addr,
                                                     logic [RegW-1:0] wdata,
                                                     logic [LevelW-1:0] src);
    irq_result_t     res;
    logic [RegW-1:0] active;
    res = '0;
    case (cmd)
      CMD_RAISE: begin
        if (shadow_mask[src]) shadow_pend[src] = 1'b1;
      end
      CMD_WRITE: begin
        if (addr == AddrBase) begin
          shadow_base = wdata;
        end else if (addr == AddrEnable) begin
          shadow_mask = wdata;
          shadow_pend = shadow_pend & wdata;
        end else if (addr == AddrAck) begin
          shadow_pend = shadow_pend & ~wdata;
        end
      end
      default: ;
    endcase
    active = shadow_pend & shadow_mask;
    // Scan downward so the lowest active source is the one left standing.
    for (int i = MaxSources - 1; i >= 0; i--) begin
      if (active[i]) res.level = LevelW'(i);
    end
    res.pending = |active;
    if (res.pending) res.vector = (VectorW'(shadow_base) + VectorW'(res.level)) << 2;
    res.deliver = (cmd == CMD_CHECK) && res.pending;
    if (cmd == CMD_READ) begin
      if (addr == AddrBase) res.read_data = shadow_base;
      else if (addr == AddrEnable) res.read_data = shadow_mask;
      else if (addr == AddrAck) res.read_data = RegW'(1) << res.level;
    end
    return res;
  endfunction

  task automatic issue_command(cmd_e cmd, logic [RegW-1:0] addr, logic [RegW-1:0] wdata,
                               logic [LevelW-1:0] src, logic has_result,
                               irq_result_t result);
    irq_result_t predicted;
    if (!steady) begin
      while ($urandom_range(0, 99) < IdlePercent) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_valid <= 1'b1;
    s_tdata <= {5'b0, src, wdata, addr};
    s_tuser <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = compute_irq_result(cmd, addr, wdata, src);
    irq_result_q.push_back(has_result ? result : predicted);
  endtask

  always @(posedge clk_i) begin
    irq_result_t got;
    irq_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got = irq_result_t'(m_axis_tdata_o);
      if (irq_result_q.size() == 0) begin
        $error("result transfer with nothing expected: %h", m_axis_tdata_o);
        mismatch_count++;
      end else begin
        want = irq_result_q.pop_front();
        if (got.read_data != want.read_data) begin
          $error("read_data: expected %0h, actual %0h", want.read_data, got.read_data);
          mismatch_count++;
        end
        if (got.pending != want.pending) begin
          $error("irq_pending: expected %0d, actual %0d", want.pending, got.pending);
          mismatch_count++;
        end
        if (got.level != want.level) begin
          $error("irq_level: expected %0d, actual %0d", want.level, got.level);
          mismatch_count++;
        end
        if (got.vector != want.vector) begin
          $error("irq_vector: expected %0d, actual %0d", want.vector, got.vector);
          mismatch_count++;
        end
        if (got.deliver != want.deliver) begin
          $error("deliver: expected %0d, actual %0d", want.deliver, got.deliver);
          mismatch_count++;
        end
      end
    end
    m_ready <= steady || ($urandom_range(0, 99) >= IdlePercent);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("priority_interrupt_controller_core_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned       pick;
    cmd_e              cmd;
    logic [RegW-1:0]   addr;
    logic [RegW-1:0]   wdata;
    logic [LevelW-1:0] src;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedRows[i]) begin
      issue_command(DirectedRows[i].cmd, DirectedRows[i].addr, DirectedRows[i].wdata,
                    DirectedRows[i].src, DirectedRows[i].has_result,
                    DirectedRows[i].result);
    end

    for (int n = 0; n < RandomItems; n++) begin
      steady = (n >= 150) && (n < 250);
      // Hold the stream off once until the block has drained completely.
      if (n == 300) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
        while (irq_result_q.size() != 0) @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) cmd = CMD_RAISE;
      else if (pick < 65) cmd = CMD_WRITE;
      else if (pick < 85) cmd = CMD_READ;
      else cmd = CMD_CHECK;
      // Mostly decoded registers, with some stray addresses mixed in.
      pick = $urandom_range(0, 9);
      if (pick == 0) addr = AddrBase;
      else if (pick <= 3) addr = AddrEnable;
      else if (pick <= 6) addr = AddrAck;
      else addr = RegW'($urandom_range(0, 255));
      wdata = RegW'($urandom_range(0, 255));
      // Keep the mask dense often enough that raises actually land.
      if (cmd == CMD_WRITE && addr == AddrEnable && $urandom_range(0, 1))
        wdata = wdata | RegW'($urandom_range(0, 255));
      src = LevelW'($urandom_range(0, 7));
      issue_command(cmd, addr, wdata, src, 1'b0, '0);
    end
    steady = 1'b0;
    s_valid <= 1'b0;

    while (irq_result_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("priority_interrupt_controller_core_tb: done, clean");
    end else begin
      $display("priority_interrupt_controller_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/pic_pkg.sv
hw/rtl/pic_prio_enc.sv
hw/rtl/priority_interrupt_controller_core.sv
tb/sv/priority_interrupt_controller_core_tb.sv
